// ===== hdl/dsr_pkg.sv =====
package dsr_pkg;

  localparam logic [6:0] TAB_IP [64] = '{
    7'd58, 7'd50, 7'd42, 7'd34, 7'd26, 7'd18, 7'd10, 7'd2,
    7'd60, 7'd52, 7'd44, 7'd36, 7'd28, 7'd20, 7'd12, 7'd4,
    7'd62, 7'd54, 7'd46, 7'd38, 7'd30, 7'd22, 7'd14, 7'd6,
    7'd64, 7'd56, 7'd48, 7'd40, 7'd32, 7'd24, 7'd16, 7'd8,
    7'd57, 7'd49, 7'd41, 7'd33, 7'd25, 7'd17, 7'd9,  7'd1,
    7'd59, 7'd51, 7'd43, 7'd35, 7'd27, 7'd19, 7'd11, 7'd3,
    7'd61, 7'd53, 7'd45, 7'd37, 7'd29, 7'd21, 7'd13, 7'd5,
    7'd63, 7'd55, 7'd47, 7'd39, 7'd31, 7'd23, 7'd15, 7'd7
  };

  localparam logic [6:0] TAB_FP [64] = '{
    7'd40, 7'd8, 7'd48, 7'd16, 7'd56, 7'd24, 7'd64, 7'd32,
    7'd39, 7'd7, 7'd47, 7'd15, 7'd55, 7'd23, 7'd63, 7'd31,
    7'd38, 7'd6, 7'd46, 7'd14, 7'd54, 7'd22, 7'd62, 7'd30,
    7'd37, 7'd5, 7'd45, 7'd13, 7'd53, 7'd21, 7'd61, 7'd29,
    7'd36, 7'd4, 7'd44, 7'd12, 7'd52, 7'd20, 7'd60, 7'd28,
    7'd35, 7'd3, 7'd43, 7'd11, 7'd51, 7'd19, 7'd59, 7'd27,
    7'd34, 7'd2, 7'd42, 7'd10, 7'd50, 7'd18, 7'd58, 7'd26,
    7'd33, 7'd1, 7'd41, 7'd9,  7'd49, 7'd17, 7'd57, 7'd25
  };

  localparam logic [6:0] TAB_PC1 [56] = '{
    7'd57, 7'd49, 7'd41, 7'd33, 7'd25, 7'd17, 7'd9,
    7'd1,  7'd58, 7'd50, 7'd42, 7'd34, 7'd26, 7'd18,
    7'd10, 7'd2,  7'd59, 7'd51, 7'd43, 7'd35, 7'd27,
    7'd19, 7'd11, 7'd3,  7'd60, 7'd52, 7'd44, 7'd36,
    7'd63, 7'd55, 7'd47, 7'd39, 7'd31, 7'd23, 7'd15,
    7'd7,  7'd62, 7'd54, 7'd46, 7'd38, 7'd30, 7'd22,
    7'd14, 7'd6,  7'd61, 7'd53, 7'd45, 7'd37, 7'd29,
    7'd21, 7'd13, 7'd5,  7'd28, 7'd20, 7'd12, 7'd4
  };

  localparam logic [5:0] TAB_PC2 [48] = '{
    6'd14, 6'd17, 6'd11, 6'd24, 6'd1,  6'd5,
    6'd3,  6'd28, 6'd15, 6'd6,  6'd21, 6'd10,
    6'd23, 6'd19, 6'd12, 6'd4,  6'd26, 6'd8,
    6'd16, 6'd7,  6'd27, 6'd20, 6'd13, 6'd2,
    6'd41, 6'd52, 6'd31, 6'd37, 6'd47, 6'd55,
    6'd30, 6'd40, 6'd51, 6'd45, 6'd33, 6'd48,
    6'd44, 6'd49, 6'd39, 6'd56, 6'd34, 6'd53,
    6'd46, 6'd42, 6'd50, 6'd36, 6'd29, 6'd32
  };

  localparam logic [5:0] TAB_E [48] = '{
    6'd32, 6'd1,  6'd2,  6'd3,  6'd4,  6'd5,
    6'd4,  6'd5,  6'd6,  6'd7,  6'd8,  6'd9,
    6'd8,  6'd9,  6'd10, 6'd11, 6'd12, 6'd13,
    6'd12, 6'd13, 6'd14, 6'd15, 6'd16, 6'd17,
    6'd16, 6'd17, 6'd18, 6'd19, 6'd20, 6'd21,
    6'd20, 6'd21, 6'd22, 6'd23, 6'd24, 6'd25,
    6'd24, 6'd25, 6'd26, 6'd27, 6'd28, 6'd29,
    6'd28, 6'd29, 6'd30, 6'd31, 6'd32, 6'd1
  };

  localparam logic [5:0] TAB_P [32] = '{
    6'd16, 6'd7,  6'd20, 6'd21, 6'd29, 6'd12, 6'd28, 6'd17,
    6'd1,  6'd15, 6'd23, 6'd26, 6'd5,  6'd18, 6'd31, 6'd10,
    6'd2,  6'd8,  6'd24, 6'd14, 6'd32, 6'd27, 6'd3,  6'd9,
    6'd19, 6'd13, 6'd30, 6'd6,  6'd22, 6'd11, 6'd4,  6'd25
  };

  localparam logic [1:0] SHIFT_CNT [16] = '{
    2'd1, 2'd1, 2'd2, 2'd2, 2'd2, 2'd2, 2'd2, 2'd2,
    2'd1, 2'd2, 2'd2, 2'd2, 2'd2, 2'd2, 2'd2, 2'd1
  };

  localparam logic [3:0] SBOX [8][64] = '{
    '{4'd14, 4'd4, 4'd13, 4'd1, 4'd2, 4'd15, 4'd11, 4'd8,
      4'd3, 4'd10, 4'd6, 4'd12, 4'd5, 4'd9, 4'd0, 4'd7,
      4'd0, 4'd15, 4'd7, 4'd4, 4'd14, 4'd2, 4'd13, 4'd1,
      4'd10, 4'd6, 4'd12, 4'd11, 4'd9, 4'd5, 4'd3, 4'd8,
      4'd4, 4'd1, 4'd14, 4'd8, 4'd13, 4'd6, 4'd2, 4'd11,
      4'd15, 4'd12, 4'd9, 4'd7, 4'd3, 4'd10, 4'd5, 4'd0,
      4'd15, 4'd12, 4'd8, 4'd2, 4'd4, 4'd9, 4'd1, 4'd7,
      4'd5, 4'd11, 4'd3, 4'd14, 4'd10, 4'd0, 4'd6, 4'd13},
    '{4'd15, 4'd1, 4'd8, 4'd14, 4'd6, 4'd11, 4'd3, 4'd4,
      4'd9, 4'd7, 4'd2, 4'd13, 4'd12, 4'd0, 4'd5, 4'd10,
      4'd3, 4'd13, 4'd4, 4'd7, 4'd15, 4'd2, 4'd8, 4'd14,
      4'd12, 4'd0, 4'd1, 4'd10, 4'd6, 4'd9, 4'd11, 4'd5,
      4'd0, 4'd14, 4'd7, 4'd11, 4'd10, 4'd4, 4'd13, 4'd1,
      4'd5, 4'd8, 4'd12, 4'd6, 4'd9, 4'd3, 4'd2, 4'd15,
      4'd13, 4'd8, 4'd10, 4'd1, 4'd3, 4'd15, 4'd4, 4'd2,
      4'd11, 4'd6, 4'd7, 4'd12, 4'd0, 4'd5, 4'd14, 4'd9},
    '{4'd10, 4'd0, 4'd9, 4'd14, 4'd6, 4'd3, 4'd15, 4'd5,
      4'd1, 4'd13, 4'd12, 4'd7, 4'd11, 4'd4, 4'd2, 4'd8,
      4'd13, 4'd7, 4'd0, 4'd9, 4'd3, 4'd4, 4'd6, 4'd10,
      4'd2, 4'd8, 4'd5, 4'd14, 4'd12, 4'd11, 4'd15, 4'd1,
      4'd13, 4'd6, 4'd4, 4'd9, 4'd8, 4'd15, 4'd3, 4'd0,
      4'd11, 4'd1, 4'd2, 4'd12, 4'd5, 4'd10, 4'd14, 4'd7,
      4'd1, 4'd10, 4'd13, 4'd0, 4'd6, 4'd9, 4'd8, 4'd7,
      4'd4, 4'd15, 4'd14, 4'd3, 4'd11, 4'd5, 4'd2, 4'd12},
    '{4'd7, 4'd13, 4'd14, 4'd3, 4'd0, 4'd6, 4'd9, 4'd10,
      4'd1, 4'd2, 4'd8, 4'd5, 4'd11, 4'd12, 4'd4, 4'd15,
      4'd13, 4'd8, 4'd11, 4'd5, 4'd6, 4'd15, 4'd0, 4'd3,
      4'd4, 4'd7, 4'd2, 4'd12, 4'd1, 4'd10, 4'd14, 4'd9,
      4'd10, 4'd6, 4'd9, 4'd0, 4'd12, 4'd11, 4'd7, 4'd13,
      4'd15, 4'd1, 4'd3, 4'd14, 4'd5, 4'd2, 4'd8, 4'd4,
      4'd3, 4'd15, 4'd0, 4'd6, 4'd10, 4'd1, 4'd13, 4'd8,
      4'd9, 4'd4, 4'd5, 4'd11, 4'd12, 4'd7, 4'd2, 4'd14},
    '{4'd2, 4'd12, 4'd4, 4'd1, 4'd7, 4'd10, 4'd11, 4'd6,
      4'd8, 4'd5, 4'd3, 4'd15, 4'd13, 4'd0, 4'd14, 4'd9,
      4'd14, 4'd11, 4'd2, 4'd12, 4'd4, 4'd7, 4'd13, 4'd1,
      4'd5, 4'd0, 4'd15, 4'd10, 4'd3, 4'd9, 4'd8, 4'd6,
      4'd4, 4'd2, 4'd1, 4'd11, 4'd10, 4'd13, 4'd7, 4'd8,
      4'd15, 4'd9, 4'd12, 4'd5, 4'd6, 4'd3, 4'd0, 4'd14,
      4'd11, 4'd8, 4'd12, 4'd7, 4'd1, 4'd14, 4'd2, 4'd13,
      4'd6, 4'd15, 4'd0, 4'd9, 4'd10, 4'd4, 4'd5, 4'd3},
    '{4'd12, 4'd1, 4'd10, 4'd15, 4'd9, 4'd2, 4'd6, 4'd8,
      4'd0, 4'd13, 4'd3, 4'd4, 4'd14, 4'd7, 4'd5, 4'd11,
      4'd10, 4'd15, 4'd4, 4'd2, 4'd7, 4'd12, 4'd9, 4'd5,
      4'd6, 4'd1, 4'd13, 4'd14, 4'd0, 4'd11, 4'd3, 4'd8,
      4'd9, 4'd14, 4'd15, 4'd5, 4'd2, 4'd8, 4'd12, 4'd3,
      4'd7, 4'd0, 4'd4, 4'd10, 4'd1, 4'd13, 4'd11, 4'd6,
      4'd4, 4'd3, 4'd2, 4'd12, 4'd9, 4'd5, 4'd15, 4'd10,
      4'd11, 4'd14, 4'd1, 4'd7, 4'd6, 4'd0, 4'd8, 4'd13},
    '{4'd4, 4'd11, 4'd2, 4'd14, 4'd15, 4'd0, 4'd8, 4'd13,
      4'd3, 4'd12, 4'd9, 4'd7, 4'd5, 4'd10, 4'd6, 4'd1,
      4'd13, 4'd0, 4'd11, 4'd7, 4'd4, 4'd9, 4'd1, 4'd10,
      4'd14, 4'd3, 4'd5, 4'd12, 4'd2, 4'd15, 4'd8, 4'd6,
      4'd1, 4'd4, 4'd11, 4'd13, 4'd12, 4'd3, 4'd7, 4'd14,
      4'd10, 4'd15, 4'd6, 4'd8, 4'd0, 4'd5, 4'd9, 4'd2,
      4'd6, 4'd11, 4'd13, 4'd8, 4'd1, 4'd4, 4'd10, 4'd7,
      4'd9, 4'd5, 4'd0, 4'd15, 4'd14, 4'd2, 4'd3, 4'd12},
    '{4'd13, 4'd2, 4'd8, 4'd4, 4'd6, 4'd15, 4'd11, 4'd1,
      4'd10, 4'd9, 4'd3, 4'd14, 4'd5, 4'd0, 4'd12, 4'd7,
      4'd1, 4'd15, 4'd13, 4'd8, 4'd10, 4'd3, 4'd7, 4'd4,
      4'd12, 4'd5, 4'd6, 4'd11, 4'd0, 4'd14, 4'd9, 4'd2,
      4'd7, 4'd11, 4'd4, 4'd1, 4'd9, 4'd12, 4'd14, 4'd2,
      4'd0, 4'd6, 4'd10, 4'd13, 4'd15, 4'd3, 4'd5, 4'd8,
      4'd2, 4'd1, 4'd14, 4'd7, 4'd4, 4'd10, 4'd8, 4'd13,
      4'd15, 4'd12, 4'd9, 4'd0, 4'd3, 4'd5, 4'd6, 4'd11}
  };

  localparam logic [3:0] LAST_ROUND = 4'd15;

  function automatic logic [63:0] perm_ip(input logic [63:0] x);
    logic [63:0] y;
    for (int i = 0; i < 64; i++) y[63-i] = x[6'(64 - int'(TAB_IP[i]))];
    return y;
  endfunction

  function automatic logic [63:0] perm_fp(input logic [63:0] x);
    logic [63:0] y;
    for (int i = 0; i < 64; i++) y[63-i] = x[6'(64 - int'(TAB_FP[i]))];
    return y;
  endfunction

  function automatic logic [55:0] perm_pc1(input logic [63:0] x);
    logic [55:0] y;
    for (int i = 0; i < 56; i++) y[55-i] = x[6'(64 - int'(TAB_PC1[i]))];
    return y;
  endfunction

  function automatic logic [47:0] perm_pc2(input logic [55:0] x);
    logic [47:0] y;
    for (int i = 0; i < 48; i++) y[47-i] = x[6'(56 - int'(TAB_PC2[i]))];
    return y;
  endfunction

  function automatic logic [47:0] perm_e(input logic [31:0] x);
    logic [47:0] y;
    for (int i = 0; i < 48; i++) y[47-i] = x[5'(32 - int'(TAB_E[i]))];
    return y;
  endfunction

  function automatic logic [31:0] perm_p(input logic [31:0] x);
    logic [31:0] y;
    for (int i = 0; i < 32; i++) y[31-i] = x[5'(32 - int'(TAB_P[i]))];
    return y;
  endfunction

  function automatic logic [27:0] rotl28(input logic [27:0] x, input logic [1:0] n);
    return (n == 2'd1) ? {x[26:0], x[27]} : {x[25:0], x[27:26]};
  endfunction

  function automatic logic [27:0] rotr28(input logic [27:0] x, input logic [1:0] n);
    return (n == 2'd1) ? {x[0], x[27:1]} : {x[1:0], x[27:2]};
  endfunction

endpackage

// ===== hdl/dsr_sbox_p.sv =====
module dsr_sbox_p
  import dsr_pkg::*;
(
  input  logic [47:0] x,
  output logic [31:0] f
);

  logic [31:0] s;

  always_comb begin
    logic [5:0] blk;
    for (int i = 0; i < 8; i++) begin
      blk = x[47-6*i -: 6];
      s[31-4*i -: 4] = SBOX[i][{blk[5], blk[0], blk[4:1]}];
    end
  end

  assign f = perm_p(s);

endmodule

// ===== hdl/des_single_round.sv =====
// One DES round per transfer, pipelined over three register stages.
// Input channel: in_data_in, in_key_in, in_round_number, in_decrypt with
// in_valid/in_ready. In round 0 in_key_in is the raw 64-bit key and goes
// through PC-1; otherwise bits 55..0 carry the C/D state and bits 63..56
// are ignored. in_decrypt selects the deciphering key schedule.
// Result channel: out_data_out (data after the round) and out_key_out
// (updated C/D state, C in the upper 28 bits) with out_valid/out_ready.
// Stage 1 does the key schedule, IP and E expansion with subkey mix; stage 2
// the S-boxes, P and the XOR into the left half; stage 3 the half swap
// (none in the last round) and IP inverse into the output register.
// One item per cycle while out_ready is high; rounds are independent.
// When the receiver stalls, each stage holds its item and the stall ripples
// back to in_ready only through stages that are full, so nothing is lost.
// Reset clears all stage valid bits; the pipeline comes up empty.
module des_single_round
  import dsr_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [63:0] in_data_in,
  input  logic [63:0] in_key_in,
  input  logic [3:0]  in_round_number,
  input  logic        in_decrypt,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [63:0] out_data_out,
  output logic [55:0] out_key_out
);

  logic        s1_v_r, s2_v_r, out_v_r;
  logic [47:0] s1_x_r;
  logic [31:0] s1_l_r, s1_rt_r, s2_l_r, s2_rt_r;
  logic        s1_last_r, s2_last_r;
  logic [55:0] s1_key_r, s2_key_r, out_key_r;
  logic [63:0] out_data_r;

  logic        out_adv, s2_adv, s1_adv;

  assign out_adv  = !out_v_r || out_ready;
  assign s2_adv   = !s2_v_r || out_adv;
  assign s1_adv   = !s1_v_r || s2_adv;
  assign in_ready = s1_adv;

  logic [55:0] key_cd, key_nxt;
  logic [27:0] c_in, d_in;
  logic [1:0]  shamt;
  logic [47:0] subkey;
  logic [63:0] blk_ip;
  logic [47:0] x_nxt;

  always_comb begin
    key_cd = (in_round_number == 4'd0) ? perm_pc1(in_key_in) : in_key_in[55:0];
    c_in   = key_cd[55:28];
    d_in   = key_cd[27:0];
    if (in_decrypt) begin
      shamt   = SHIFT_CNT[~in_round_number];
      subkey  = perm_pc2(key_cd);
      key_nxt = {rotr28(c_in, shamt), rotr28(d_in, shamt)};
    end else begin
      shamt   = SHIFT_CNT[in_round_number];
      key_nxt = {rotl28(c_in, shamt), rotl28(d_in, shamt)};
      subkey  = perm_pc2(key_nxt);
    end
    blk_ip = perm_ip(in_data_in);
    x_nxt  = perm_e(blk_ip[31:0]) ^ subkey;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else if (s1_adv) begin
      s1_v_r <= in_valid;
    end
    if (s1_adv && in_valid) begin
      s1_x_r    <= x_nxt;
      s1_l_r    <= blk_ip[63:32];
      s1_rt_r   <= blk_ip[31:0];
      s1_last_r <= (in_round_number == LAST_ROUND);
      s1_key_r  <= key_nxt;
    end
  end

  logic [31:0] f;

  dsr_sbox_p u_sbox_p (
    .x (s1_x_r),
    .f (f)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_v_r <= 1'b0;
    end else if (s2_adv) begin
      s2_v_r <= s1_v_r;
    end
    if (s2_adv && s1_v_r) begin
      s2_l_r    <= s1_l_r ^ f;
      s2_rt_r   <= s1_rt_r;
      s2_last_r <= s1_last_r;
      s2_key_r  <= s1_key_r;
    end
  end

  logic [63:0] blk_out;

  assign blk_out = s2_last_r ? {s2_l_r, s2_rt_r} : {s2_rt_r, s2_l_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (out_adv) begin
      out_v_r <= s2_v_r;
    end
    if (out_adv && s2_v_r) begin
      out_data_r <= perm_fp(blk_out);
      out_key_r  <= s2_key_r;
    end
  end

  assign out_valid    = out_v_r;
  assign out_data_out = out_data_r;
  assign out_key_out  = out_key_r;

endmodule

// ===== dv/tb.sv =====
module tb
  import dsr_pkg::*;
;

  typedef struct packed {
    logic [63:0] data;
    logic [55:0] key;
  } round_out_t;

  class round_tracker;
    round_out_t pending[$];
    int errors;
    int rounds;
    int decrypts;
    int last_rounds;

    function bit take(input logic [63:0] src, input int width, input int pos);
      return src[width - pos];
    endfunction

    function round_out_t des_round(input logic [63:0] data, input logic [63:0] key,
                                   input logic [3:0] rnd, input logic dec);
      round_out_t res;
      logic [55:0] cd;
      logic [27:0] c, d;
      logic [47:0] sub, ex;
      logic [63:0] blk, fin;
      logic [31:0] lh, rh, sv, fv;
      logic [5:0] six;
      int n;
      if (rnd == 4'd0) begin
        for (int i = 0; i < 56; i++) cd = {cd[54:0], take(key, 64, TAB_PC1[i])};
      end else begin
        cd = key[55:0];
      end
      c = cd[55:28];
      d = cd[27:0];
      if (dec) begin
        n = SHIFT_CNT[LAST_ROUND - rnd];
        for (int i = 0; i < 48; i++) sub = {sub[46:0], take({8'b0, cd}, 56, TAB_PC2[i])};
        c = (c >> n) | (c << (28 - n));
        d = (d >> n) | (d << (28 - n));
        cd = {c, d};
      end else begin
        n = SHIFT_CNT[rnd];
        c = (c << n) | (c >> (28 - n));
        d = (d << n) | (d >> (28 - n));
        cd = {c, d};
        for (int i = 0; i < 48; i++) sub = {sub[46:0], take({8'b0, cd}, 56, TAB_PC2[i])};
      end
      for (int i = 0; i < 64; i++) blk = {blk[62:0], take(data, 64, TAB_IP[i])};
      lh = blk[63:32];
      rh = blk[31:0];
      for (int i = 0; i < 48; i++) ex = {ex[46:0], take({32'b0, rh}, 32, TAB_E[i])};
      ex = ex ^ sub;
      for (int i = 0; i < 8; i++) begin
        six = ex[47 - 6 * i -: 6];
        sv = {sv[27:0], SBOX[i][int'({six[5], six[0]}) * 16 + int'(six[4:1])]};
      end
      for (int i = 0; i < 32; i++) fv = {fv[30:0], take({32'b0, sv}, 32, TAB_P[i])};
      lh = lh ^ fv;
      blk = (rnd != LAST_ROUND) ? {rh, lh} : {lh, rh};
      for (int i = 0; i < 64; i++) fin = {fin[62:0], take(blk, 64, TAB_FP[i])};
      res.data = fin;
      res.key = cd;
      return res;
    endfunction

    function void note_input(input logic [63:0] data, input logic [63:0] key,
                             input logic [3:0] rnd, input logic dec);
      pending.push_back(des_round(data, key, rnd, dec));
      rounds++;
      if (dec) decrypts++;
      if (rnd == LAST_ROUND) last_rounds++;
    endfunction

    function void check_result(input logic [63:0] data, input logic [55:0] key);
      round_out_t exp_out;
      if (pending.size() == 0) begin
        $error("unexpected transfer: data_out %h key_out %h", data, key);
        errors++;
        return;
      end
      exp_out = pending.pop_front();
      if (data !== exp_out.data) begin
        $error("data_out expected %h actual %h", exp_out.data, data);
        errors++;
      end
      if (key !== exp_out.key) begin
        $error("key_out expected %h actual %h", exp_out.key, key);
        errors++;
      end
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [63:0] in_data_in = '0;
  logic [63:0] in_key_in = '0;
  logic [3:0]  in_round_number = '0;
  logic        in_decrypt = 1'b0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [63:0] out_data_out;
  logic [55:0] out_key_out;

  int  send_idle = 0;
  int  recv_stall = 0;
  logic out_hold = 1'b0;
  int  hold_len = 300;
  round_tracker tracker = new();

  des_single_round DUT (.*);

  always #5 clk = ~clk;

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) tracker.check_result(out_data_out, out_key_out);
    out_ready <= !out_hold && ($urandom_range(99) >= recv_stall);
  end

  task automatic send_round(input logic [63:0] data, input logic [63:0] key,
                            input logic [3:0] rnd, input logic dec);
    while ($urandom_range(99) < send_idle) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data_in <= data;
    in_key_in <= key;
    in_round_number <= rnd;
    in_decrypt <= dec;
    do @(posedge clk); while (!in_ready);
    tracker.note_input(data, key, rnd, dec);
  endtask

  function automatic logic [63:0] rand_word();
    case ($urandom_range(9))
      0: return '0;
      1: return '1;
      default: return {$urandom, $urandom};
    endcase
  endfunction

  task automatic send_random(input int count);
    for (int i = 0; i < count; i++)
      send_round(rand_word(), rand_word(), 4'($urandom_range(15)), 1'($urandom_range(1)));
  endtask

  initial begin
    #2000000;
    $display("*** FAILED ***");
    $finish;
  end

  initial begin
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    send_round('0, '0, 4'd0, 1'b0);
    send_round('1, '1, 4'd0, 1'b1);
    send_round(64'h0123456789ABCDEF, 64'h133457799BBCDFF1, 4'd0, 1'b0);
    send_round(64'h0123456789ABCDEF, 64'h133457799BBCDFF1, 4'd0, 1'b1);
    send_round(64'h0123456789ABCDEF, 64'h0101010101010101, 4'd0, 1'b0);
    send_round('1, 64'hFF00_0000_0000_0000, 4'd5, 1'b0);
    send_round('0, '1, LAST_ROUND, 1'b0);
    send_round('1, 64'h00FF_FFFF_FFFF_FFFF, LAST_ROUND, 1'b1);
    for (int r = 0; r < 16; r++)
      send_round({$urandom, $urandom}, {$urandom, $urandom}, 4'(r), 1'(r));

    // fill the pipeline while the output is held
    fork begin
      out_hold <= 1'b1;
      repeat (hold_len) @(posedge clk);
      out_hold <= 1'b0;
    end join_none
    send_random(332);

    send_idle = 64;
    recv_stall = 0;
    send_random(332);
    send_idle = 0;
    recv_stall = 64;
    send_random(332);
    send_idle = 31;
    recv_stall = 31;
    send_random(332);
    in_valid <= 1'b0;

    while (tracker.pending.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);

    $display("Ran %0d single rounds (%0d deciphering, %0d final rounds without swap)",
             tracker.rounds, tracker.decrypts, tracker.last_rounds);
    $display("Pacing: free-running, sender gaps, receiver stalls, both, and a %0d-cycle hold",
             hold_len);
    if (tracker.errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
